// ----- hdl/sdhc_pkg.sv -----
// Shared types and constants for the SD host controller with DMA channels.
package sdhc_pkg;

    localparam logic [2:0] CMD_REG_WRITE = 3'd0;
    localparam logic [2:0] CMD_REG_READ  = 3'd1;
    localparam logic [2:0] CMD_RESPONSE  = 3'd2;
    localparam logic [2:0] CMD_RX_BYTE   = 3'd3;
    localparam logic [2:0] CMD_TX_BYTE   = 3'd4;
    localparam logic [2:0] CMD_ENABLE    = 3'd5;

    localparam logic [2:0] KIND_NONE      = 3'd0;
    localparam logic [2:0] KIND_READ_DATA = 3'd1;
    localparam logic [2:0] KIND_MEM_WRITE = 3'd2;
    localparam logic [2:0] KIND_MEM_FETCH = 3'd3;
    localparam logic [2:0] KIND_CARD_CMD  = 3'd4;
    localparam logic [2:0] KIND_CARD_BYTE = 3'd5;

    localparam logic [4:0] REG_RX_ADDR  = 5'd0;
    localparam logic [4:0] REG_RX_LEN   = 5'd1;
    localparam logic [4:0] REG_RX_CFG   = 5'd2;
    localparam logic [4:0] REG_TX_ADDR  = 5'd4;
    localparam logic [4:0] REG_TX_LEN   = 5'd5;
    localparam logic [4:0] REG_TX_CFG   = 5'd6;
    localparam logic [4:0] REG_CMD_OP   = 5'd8;
    localparam logic [4:0] REG_CMD_ARG  = 5'd9;
    localparam logic [4:0] REG_DATA_SET = 5'd10;
    localparam logic [4:0] REG_START    = 5'd11;
    localparam logic [4:0] REG_RESP0    = 5'd12;
    localparam logic [4:0] REG_RESP1    = 5'd13;
    localparam logic [4:0] REG_RESP2    = 5'd14;
    localparam logic [4:0] REG_RESP3    = 5'd15;
    localparam logic [4:0] REG_CLK_DIV  = 5'd16;
    localparam logic [4:0] REG_STATUS   = 5'd17;

    localparam logic [2:0] RSP_KIND_FAILED = 3'd0;
    localparam logic [2:0] RSP_KIND_SHORT  = 3'd2;
    localparam logic [2:0] RSP_KIND_LONG   = 3'd3;
    localparam logic [2:0] RSP_TYPE_NONE   = 3'd0;
    localparam logic [2:0] RSP_TYPE_LONG   = 3'h3;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_WAIT = 2'd1;
    localparam logic [1:0] PH_RX   = 2'd2;
    localparam logic [1:0] PH_TX   = 2'd3;

    // Compact status: EOT, ERR, response timeout, data timeout.
    localparam logic [3:0] ST_EOT     = 4'b0001;
    localparam logic [3:0] ST_ERR     = 4'b0010;
    localparam logic [3:0] ST_RSP_TO  = 4'b0100;
    localparam logic [3:0] ST_DATA_TO = 4'b1000;

    localparam int CFG_CONT_BIT = 0;
    localparam int CFG_EN_BIT   = 4;
    localparam int CFG_CLR_BIT  = 6;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [4:0]  reg_index;
        logic [31:0] write_data;
        logic [2:0]  response_kind;
        logic        card_data_ready;
        logic [31:0] response_word_a;
        logic [31:0] response_word_b;
        logic [31:0] response_word_c;
        logic [31:0] response_word_d;
        logic [7:0]  data_byte;
    } in_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] read_data;
        logic [31:0] mem_address;
        logic [7:0]  byte_value;
        logic [5:0]  card_cmd_index;
        logic [31:0] card_cmd_arg;
        logic        eot_line;
        logic        err_line;
        logic        rx_channel_pulse;
        logic        tx_channel_pulse;
        logic        last;
    } out_t;

    typedef struct packed {
        logic [1:0] count;
        out_t       first;
        out_t       second;
    } push_t;

endpackage

// ----- hdl/sdhc_regs.sv -----
// Register file, command sequencer and DMA channel logic of the SD host controller.
module sdhc_regs (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            accept,
    input  sdhc_pkg::in_t   item,
    output sdhc_pkg::push_t push
);

    logic        enabled_reg, enabled_next;
    logic [31:0] rx_start_reg, rx_start_next, rx_len_reg, rx_len_next;
    logic [31:0] rx_cur_reg, rx_cur_next, rx_rem_reg, rx_rem_next;
    logic [6:0]  rx_ctl_reg, rx_ctl_next;
    logic [31:0] tx_start_reg, tx_start_next, tx_len_reg, tx_len_next;
    logic [31:0] tx_cur_reg, tx_cur_next, tx_rem_reg, tx_rem_next;
    logic [6:0]  tx_ctl_reg, tx_ctl_next;
    logic [5:0]  cmd_idx_reg, cmd_idx_next;
    logic [2:0]  rsp_type_reg, rsp_type_next;
    logic [31:0] cmd_arg_reg, cmd_arg_next;
    logic [31:0] setup_reg, setup_next;
    logic [31:0] resp_reg [4];
    logic [31:0] resp_next [4];
    logic [31:0] clk_div_reg, clk_div_next;
    logic [3:0]  status_reg, status_next;
    logic [18:0] left_reg, left_next;
    logic [1:0]  phase_reg, phase_next;
    logic [1:0]  levels_reg, levels_next;

    logic [18:0] size;
    logic [31:0] read_value;
    logic        refresh;
    logic        rsp_ok;
    logic        pulse_rx, pulse_tx;
    sdhc_pkg::out_t r0, r1;
    logic [1:0]  nres;

    assign size = ({9'd0, setup_reg[25:16]} + 19'd1) * ({11'd0, setup_reg[15:8]} + 19'd1);

    always_comb begin
        unique case (item.reg_index)
            sdhc_pkg::REG_RX_ADDR: read_value = rx_cur_reg;
            sdhc_pkg::REG_RX_LEN:  read_value = rx_rem_reg;
            sdhc_pkg::REG_RX_CFG:  read_value = {25'd0, rx_ctl_reg};
            sdhc_pkg::REG_TX_ADDR: read_value = tx_cur_reg;
            sdhc_pkg::REG_TX_LEN:  read_value = tx_rem_reg;
            sdhc_pkg::REG_TX_CFG:  read_value = {25'd0, tx_ctl_reg};
            sdhc_pkg::REG_RESP0, sdhc_pkg::REG_RESP1, sdhc_pkg::REG_RESP2,
            sdhc_pkg::REG_RESP3:   read_value = resp_reg[item.reg_index[1:0]];
            sdhc_pkg::REG_CLK_DIV: read_value = clk_div_reg;
            sdhc_pkg::REG_STATUS:
                read_value = {7'd0, status_reg[3], 7'd0, status_reg[2], 14'd0, status_reg[1:0]};
            default:               read_value = 32'd0;
        endcase
        if (!enabled_reg) begin
            read_value = 32'd0;
        end
    end

    always_comb begin
        enabled_next  = enabled_reg;
        rx_start_next = rx_start_reg;
        rx_len_next   = rx_len_reg;
        rx_cur_next   = rx_cur_reg;
        rx_rem_next   = rx_rem_reg;
        rx_ctl_next   = rx_ctl_reg;
        tx_start_next = tx_start_reg;
        tx_len_next   = tx_len_reg;
        tx_cur_next   = tx_cur_reg;
        tx_rem_next   = tx_rem_reg;
        tx_ctl_next   = tx_ctl_reg;
        cmd_idx_next  = cmd_idx_reg;
        rsp_type_next = rsp_type_reg;
        cmd_arg_next  = cmd_arg_reg;
        setup_next    = setup_reg;
        resp_next     = resp_reg;
        clk_div_next  = clk_div_reg;
        status_next   = status_reg;
        left_next     = left_reg;
        phase_next    = phase_reg;
        levels_next   = levels_reg;
        refresh       = 1'b0;
        rsp_ok        = 1'b1;
        pulse_rx      = 1'b0;
        pulse_tx      = 1'b0;
        r0            = '0;
        r1            = '0;
        nres          = 2'd0;

        unique case (item.cmd)
            sdhc_pkg::CMD_REG_WRITE: begin
                if (enabled_reg) begin
                    unique case (item.reg_index)
                        sdhc_pkg::REG_RX_ADDR: rx_start_next = item.write_data;
                        sdhc_pkg::REG_RX_LEN:  rx_len_next = item.write_data;
                        sdhc_pkg::REG_RX_CFG: begin
                            if (!rx_ctl_reg[sdhc_pkg::CFG_EN_BIT]
                                    && item.write_data[sdhc_pkg::CFG_EN_BIT]) begin
                                rx_cur_next = rx_start_reg;
                                rx_rem_next = rx_len_reg;
                            end
                            if (item.write_data[sdhc_pkg::CFG_CLR_BIT]) begin
                                rx_cur_next = 32'd0;
                                rx_rem_next = 32'd0;
                                rx_ctl_next = {6'd0, item.write_data[sdhc_pkg::CFG_CONT_BIT]};
                            end else begin
                                rx_ctl_next = {1'b0, item.write_data[5:0]};
                            end
                        end
                        sdhc_pkg::REG_TX_ADDR: tx_start_next = item.write_data;
                        sdhc_pkg::REG_TX_LEN:  tx_len_next = item.write_data;
                        sdhc_pkg::REG_TX_CFG: begin
                            if (!tx_ctl_reg[sdhc_pkg::CFG_EN_BIT]
                                    && item.write_data[sdhc_pkg::CFG_EN_BIT]) begin
                                tx_cur_next = tx_start_reg;
                                tx_rem_next = tx_len_reg;
                            end
                            if (item.write_data[sdhc_pkg::CFG_CLR_BIT]) begin
                                tx_cur_next = 32'd0;
                                tx_rem_next = 32'd0;
                                tx_ctl_next = {6'd0, item.write_data[sdhc_pkg::CFG_CONT_BIT]};
                            end else begin
                                tx_ctl_next = {1'b0, item.write_data[5:0]};
                            end
                        end
                        sdhc_pkg::REG_CMD_OP: begin
                            cmd_idx_next  = item.write_data[13:8];
                            rsp_type_next = item.write_data[2:0];
                        end
                        sdhc_pkg::REG_CMD_ARG:  cmd_arg_next = item.write_data;
                        sdhc_pkg::REG_DATA_SET: setup_next = item.write_data;
                        sdhc_pkg::REG_START: begin
                            if (phase_reg == sdhc_pkg::PH_IDLE) begin
                                status_next       = status_reg & (sdhc_pkg::ST_EOT | sdhc_pkg::ST_ERR);
                                phase_next        = sdhc_pkg::PH_WAIT;
                                r0.kind           = sdhc_pkg::KIND_CARD_CMD;
                                r0.card_cmd_index = cmd_idx_reg;
                                r0.card_cmd_arg   = cmd_arg_reg;
                                nres              = 2'd1;
                            end
                        end
                        sdhc_pkg::REG_CLK_DIV: clk_div_next = item.write_data;
                        sdhc_pkg::REG_STATUS: begin
                            status_next = status_reg & ~{2'b00, item.write_data[1:0]};
                            refresh     = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            sdhc_pkg::CMD_REG_READ: begin
                r0.kind      = sdhc_pkg::KIND_READ_DATA;
                r0.read_data = read_value;
                nres         = 2'd1;
                if (enabled_reg && item.reg_index == sdhc_pkg::REG_STATUS) begin
                    status_next = 4'd0;
                end
            end
            sdhc_pkg::CMD_RESPONSE: begin
                if (phase_reg == sdhc_pkg::PH_WAIT) begin
                    if (item.response_kind == sdhc_pkg::RSP_KIND_FAILED) begin
                        status_next = status_reg | sdhc_pkg::ST_RSP_TO | sdhc_pkg::ST_ERR;
                        phase_next  = sdhc_pkg::PH_IDLE;
                        refresh     = 1'b1;
                    end else begin
                        for (int i = 0; i < 4; i++) begin
                            resp_next[i] = 32'd0;
                        end
                        if (rsp_type_reg != sdhc_pkg::RSP_TYPE_NONE) begin
                            if (item.response_kind == sdhc_pkg::RSP_KIND_SHORT
                                    && rsp_type_reg != sdhc_pkg::RSP_TYPE_LONG) begin
                                resp_next[0] = item.response_word_a;
                            end else if (item.response_kind == sdhc_pkg::RSP_KIND_LONG) begin
                                resp_next[3] = item.response_word_a;
                                resp_next[2] = item.response_word_b;
                                resp_next[1] = item.response_word_c;
                                resp_next[0] = item.response_word_d;
                            end else begin
                                rsp_ok = 1'b0;
                            end
                        end
                        if (!rsp_ok) begin
                            status_next = status_reg | sdhc_pkg::ST_RSP_TO | sdhc_pkg::ST_ERR;
                            phase_next  = sdhc_pkg::PH_IDLE;
                            refresh     = 1'b1;
                        end else if (!setup_reg[0]) begin
                            status_next = status_reg | sdhc_pkg::ST_EOT;
                            phase_next  = sdhc_pkg::PH_IDLE;
                            refresh     = 1'b1;
                        end else if (setup_reg[1]) begin
                            if (rx_ctl_reg[sdhc_pkg::CFG_EN_BIT] && item.card_data_ready) begin
                                left_next  = size;
                                phase_next = sdhc_pkg::PH_RX;
                            end else begin
                                status_next = status_reg | sdhc_pkg::ST_DATA_TO | sdhc_pkg::ST_ERR;
                                phase_next  = sdhc_pkg::PH_IDLE;
                                refresh     = 1'b1;
                            end
                        end else if (!tx_ctl_reg[sdhc_pkg::CFG_EN_BIT] || tx_rem_reg == 32'd0) begin
                            status_next = status_reg | sdhc_pkg::ST_DATA_TO | sdhc_pkg::ST_ERR;
                            phase_next  = sdhc_pkg::PH_IDLE;
                            refresh     = 1'b1;
                        end else begin
                            left_next      = size;
                            phase_next     = sdhc_pkg::PH_TX;
                            r0.kind        = sdhc_pkg::KIND_MEM_FETCH;
                            r0.mem_address = tx_cur_reg;
                            nres           = 2'd1;
                        end
                    end
                end
            end
            sdhc_pkg::CMD_RX_BYTE: begin
                if (phase_reg == sdhc_pkg::PH_RX) begin
                    if (rx_rem_reg == 32'd0) begin
                        status_next = status_reg | sdhc_pkg::ST_DATA_TO | sdhc_pkg::ST_ERR;
                        phase_next  = sdhc_pkg::PH_IDLE;
                        refresh     = 1'b1;
                    end else begin
                        r0.kind        = sdhc_pkg::KIND_MEM_WRITE;
                        r0.mem_address = rx_cur_reg;
                        r0.byte_value  = item.data_byte;
                        nres           = 2'd1;
                        rx_cur_next    = rx_cur_reg + 32'd1;
                        rx_rem_next    = rx_rem_reg - 32'd1;
                        left_next      = left_reg - 19'd1;
                        if (rx_rem_next == 32'd0) begin
                            pulse_rx = 1'b1;
                            if (rx_ctl_reg[sdhc_pkg::CFG_CONT_BIT]) begin
                                rx_rem_next = rx_len_reg;
                                rx_cur_next = rx_start_reg;
                            end else begin
                                rx_ctl_next[sdhc_pkg::CFG_EN_BIT] = 1'b0;
                            end
                        end
                        if (left_next == 19'd0) begin
                            status_next = status_reg | sdhc_pkg::ST_EOT;
                            phase_next  = sdhc_pkg::PH_IDLE;
                            refresh     = 1'b1;
                        end
                    end
                end
            end
            sdhc_pkg::CMD_TX_BYTE: begin
                if (phase_reg == sdhc_pkg::PH_TX) begin
                    if (tx_rem_reg == 32'd0) begin
                        status_next = status_reg | sdhc_pkg::ST_DATA_TO | sdhc_pkg::ST_ERR;
                        phase_next  = sdhc_pkg::PH_IDLE;
                        refresh     = 1'b1;
                    end else begin
                        r0.kind       = sdhc_pkg::KIND_CARD_BYTE;
                        r0.byte_value = item.data_byte;
                        nres          = 2'd1;
                        tx_cur_next   = tx_cur_reg + 32'd1;
                        tx_rem_next   = tx_rem_reg - 32'd1;
                        left_next     = left_reg - 19'd1;
                        if (tx_rem_next == 32'd0) begin
                            pulse_tx = 1'b1;
                            if (tx_ctl_reg[sdhc_pkg::CFG_CONT_BIT]) begin
                                tx_rem_next = tx_len_reg;
                                tx_cur_next = tx_start_reg;
                            end else begin
                                tx_ctl_next[sdhc_pkg::CFG_EN_BIT] = 1'b0;
                            end
                        end
                        if (left_next == 19'd0) begin
                            status_next = status_reg | sdhc_pkg::ST_EOT;
                            phase_next  = sdhc_pkg::PH_IDLE;
                            refresh     = 1'b1;
                        end else if (tx_rem_next != 32'd0) begin
                            r1.kind        = sdhc_pkg::KIND_MEM_FETCH;
                            r1.mem_address = tx_cur_next;
                            nres           = 2'd2;
                        end else begin
                            status_next = status_reg | sdhc_pkg::ST_DATA_TO | sdhc_pkg::ST_ERR;
                            phase_next  = sdhc_pkg::PH_IDLE;
                            refresh     = 1'b1;
                        end
                    end
                end
            end
            sdhc_pkg::CMD_ENABLE: enabled_next = item.write_data[0];
            default: ;
        endcase

        if (refresh) begin
            levels_next = status_next[1:0];
        end
        if (nres == 2'd0) begin
            r0.kind = sdhc_pkg::KIND_NONE;
            nres    = 2'd1;
        end
        r0.eot_line = levels_next[0];
        r0.err_line = levels_next[1];
        r1.eot_line = levels_next[0];
        r1.err_line = levels_next[1];
        if (nres == 2'd2) begin
            r1.last             = 1'b1;
            r1.rx_channel_pulse = pulse_rx;
            r1.tx_channel_pulse = pulse_tx;
        end else begin
            r0.last             = 1'b1;
            r0.rx_channel_pulse = pulse_rx;
            r0.tx_channel_pulse = pulse_tx;
        end
    end

    assign push.count  = accept ? nres : 2'd0;
    assign push.first  = r0;
    assign push.second = r1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enabled_reg  <= 1'b0;
            rx_start_reg <= 32'd0;
            rx_len_reg   <= 32'd0;
            rx_cur_reg   <= 32'd0;
            rx_rem_reg   <= 32'd0;
            rx_ctl_reg   <= 7'd0;
            tx_start_reg <= 32'd0;
            tx_len_reg   <= 32'd0;
            tx_cur_reg   <= 32'd0;
            tx_rem_reg   <= 32'd0;
            tx_ctl_reg   <= 7'd0;
            cmd_idx_reg  <= 6'd0;
            rsp_type_reg <= 3'd0;
            cmd_arg_reg  <= 32'd0;
            setup_reg    <= 32'd0;
            for (int i = 0; i < 4; i++) begin
                resp_reg[i] <= 32'd0;
            end
            clk_div_reg  <= 32'd0;
            status_reg   <= 4'd0;
            left_reg     <= 19'd0;
            phase_reg    <= sdhc_pkg::PH_IDLE;
            levels_reg   <= 2'd0;
        end else if (accept) begin
            enabled_reg  <= enabled_next;
            rx_start_reg <= rx_start_next;
            rx_len_reg   <= rx_len_next;
            rx_cur_reg   <= rx_cur_next;
            rx_rem_reg   <= rx_rem_next;
            rx_ctl_reg   <= rx_ctl_next;
            tx_start_reg <= tx_start_next;
            tx_len_reg   <= tx_len_next;
            tx_cur_reg   <= tx_cur_next;
            tx_rem_reg   <= tx_rem_next;
            tx_ctl_reg   <= tx_ctl_next;
            cmd_idx_reg  <= cmd_idx_next;
            rsp_type_reg <= rsp_type_next;
            cmd_arg_reg  <= cmd_arg_next;
            setup_reg    <= setup_next;
            resp_reg     <= resp_next;
            clk_div_reg  <= clk_div_next;
            status_reg   <= status_next;
            left_reg     <= left_next;
            phase_reg    <= phase_next;
            levels_reg   <= levels_next;
        end
    end

endmodule

// ----- hdl/sdhc_out_queue.sv -----
// Four-entry result queue that takes up to two beats per cycle and issues one per cycle while m_ready is high.
module sdhc_out_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  sdhc_pkg::push_t push,
    output logic            room,
    output logic            m_valid,
    input  logic            m_ready,
    output sdhc_pkg::out_t  m_data
);

    sdhc_pkg::out_t q_reg [4];
    logic [1:0] head_reg, head_next, tail_reg, tail_next;
    logic [2:0] count_reg, count_next;
    logic       pop;

    assign pop     = m_valid && m_ready;
    assign m_valid = count_reg != 3'd0;
    assign m_data  = q_reg[head_reg];
    assign room    = count_reg <= 3'd2;

    assign head_next  = head_reg + {1'b0, pop};
    assign tail_next  = tail_reg + push.count;
    assign count_next = count_reg + {1'b0, push.count} - {2'b00, pop};

    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            q_reg[tail_reg] <= push.first;
        end
        if (push.count == 2'd2) begin
            q_reg[tail_reg + 2'd1] <= push.second;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= 2'd0;
            tail_reg  <= 2'd0;
            count_reg <= 3'd0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

endmodule

// ----- hdl/sdio_dma_host_controller.sv -----
// Top level of the SD host controller with receive and transmit DMA channels.
// The s_ channel carries one event per beat: a register write or read, the
// card's command response, a byte from the card, a byte fetched from memory,
// or the enable line. The m_ channel returns the resulting beats in order:
// read data, memory writes, memory fetch requests, card commands, bytes to
// the card and empty beats, each with the interrupt levels; the final beat
// of an event has last set and carries the channel pulses.
// An event is applied to the register state in the cycle it is accepted, and
// its result beats enter the result queue at that clock edge, behind any
// beats still queued. Most events produce one beat and a transmit byte may
// produce two; one-beat events go at one per cycle while the receiver keeps
// up, the rate set by the one-beat-per-cycle output of the four-entry queue.
// s_ready is high while the queue has room for two beats; when the receiver
// stalls the queue fills and s_ready drops, and no beat is lost.
// Synchronous active-low reset clears all registers, status, the phase and
// the queue; s_ready is high and m_valid low on the first cycle after it.
module sdio_dma_host_controller (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  sdhc_pkg::in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output sdhc_pkg::out_t m_data
);

    sdhc_pkg::push_t push;
    logic            accept;

    assign accept = s_valid && s_ready;

    sdhc_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .item    (s_data),
        .push    (push)
    );

    sdhc_out_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .room    (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// ----- hdl/sdhc_checker.sv -----
// Port-level checks for the SD host controller and their binding.
module sdhc_checker (
    input logic           aclk,
    input logic           aresetn,
    input logic           s_ready,
    input logic           m_valid,
    input logic           m_ready,
    input sdhc_pkg::out_t m_data
);

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid && s_ready)
        else $error("Result queue not empty after reset.");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("Stalled result beat changed.");

    a_pair_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_data.last |=> m_valid)
        else $error("Second beat of an event did not follow.");

    a_first_of_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.last |-> m_data.kind == sdhc_pkg::KIND_CARD_BYTE)
        else $error("Non-final beat is not a byte to the card.");

endmodule

bind sdio_dma_host_controller sdhc_checker u_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
